FILE: src/bpce_pkg.sv
// ----------------------------------------------------------------------------
// bpce_pkg
// Types and constants shared by the button panel command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpce_pkg;

  // Stream widths. The input request packs direction buttons, grab, place,
  // emergency and the knob count; the result packs command code and data.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  localparam int DIR_FIELD_W       = 4;
  localparam int DIR_MAX           = 8;
  localparam int DIR_COUNT_DEFAULT = 4;
  localparam int DIR_IDX_W         = $clog2(DIR_MAX);

  localparam int MAX_CMDS = 3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd9;
  localparam logic [7:0] POWER_CENTER    = 8'd100;
  localparam logic [7:0] POWER_MAX       = 8'd200;
  localparam logic [7:0] POWER_MIN       = 8'd0;

  localparam logic [3:0] CMD_STOP      = 4'd4;
  localparam logic [3:0] CMD_GRAB      = 4'd5;
  localparam logic [3:0] CMD_PLACE     = 4'd6;
  localparam logic [3:0] CMD_SET_POWER = 4'd7;
  localparam logic [3:0] CMD_EMERGENCY = 4'd8;

  typedef struct packed {
    logic signed [31:0]     knob_count;
    logic                   emergency_button;
    logic                   place_button;
    logic                   grab_button;
    logic [DIR_FIELD_W-1:0] direction_buttons;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] code;
  } cmd_t;

  // Commands of one tick, in emission order from entry 0.
  typedef struct packed {
    logic [1:0]          count;
    cmd_t [MAX_CMDS-1:0] cmds;
  } tick_result_t;

endpackage

`default_nettype wire

FILE: src/bpce_eval.sv
// ----------------------------------------------------------------------------
// bpce_eval
// Evaluates one tick against the stored button samples and power state.
// ----------------------------------------------------------------------------
`default_nettype none

module bpce_eval #(
  parameter int DIRECTION_COUNT = bpce_pkg::DIR_COUNT_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  bpce_pkg::item_t              item,
  input  wire                          fire,
  input  wire [7:0]                    threshold,
  output bpce_pkg::tick_result_t       res
);
  import bpce_pkg::*;

  logic [DIRECTION_COUNT-1:0] direction_prev, direction_prev_next;
  logic [1:0]                 other_prev, other_prev_next;
  logic [7:0]                 reported_power, reported_power_next;
  logic                       halted, halted_next;

  logic [DIR_MAX-1:0]         dirs_ext;
  logic [DIRECTION_COUNT-1:0] dir_now, dir_press, scanned;
  logic                       press_found;
  logic [DIR_IDX_W-1:0]       press_idx;
  logic                       any_held, any_released;
  logic                       grab_rel, place_rel;

  logic signed [31:0]         knob_adj, half;
  logic [7:0]                 power;
  logic signed [8:0]          diff;
  logic [7:0]                 diff_mag;
  logic                       power_report;

  assign dirs_ext  = {{(DIR_MAX-DIR_FIELD_W){1'b0}}, item.direction_buttons};
  assign dir_now   = dirs_ext[DIRECTION_COUNT-1:0];
  assign dir_press = dir_now & ~direction_prev;

  // Scan stops at the first press; later buttons are left out of this tick.
  always_comb begin
    press_found = 1'b0;
    press_idx   = '0;
    scanned     = '0;
    for (int i = 0; i < DIRECTION_COUNT; i++) begin
      scanned[i] = !press_found;
      if (!press_found && dir_press[i]) begin
        press_found = 1'b1;
        press_idx   = DIR_IDX_W'(i);
      end
    end
  end

  assign any_held     = |(dir_now & scanned);
  assign any_released = |(~dir_now & direction_prev & scanned);

  assign grab_rel  = !item.grab_button && other_prev[0];
  assign place_rel = !grab_rel && !item.place_button && other_prev[1];

  // Division by two truncating toward zero: bias negative counts by one.
  assign knob_adj = item.knob_count + {31'b0, item.knob_count[31]};
  assign half     = knob_adj >>> 1;

  always_comb begin
    if (half < -32'sd100) begin
      power = POWER_MIN;
    end else if (half > 32'sd100) begin
      power = POWER_MAX;
    end else begin
      power = half[7:0] + POWER_CENTER;
    end
  end

  assign diff         = $signed({1'b0, power}) - $signed({1'b0, reported_power});
  assign diff_mag     = diff[8] ? 8'(-diff) : diff[7:0];
  assign power_report = diff_mag > threshold;

  always_comb begin
    res                 = '0;
    direction_prev_next = direction_prev;
    other_prev_next     = other_prev;
    reported_power_next = reported_power;
    halted_next         = halted;
    if (halted) begin
      res.count = 2'd0;
    end else if (item.emergency_button) begin
      res.cmds[0] = '{data: 8'd0, code: CMD_EMERGENCY};
      res.count   = 2'd1;
      halted_next = 1'b1;
    end else begin
      direction_prev_next = (dir_now & scanned) | (direction_prev & ~scanned);
      other_prev_next[0]  = item.grab_button;
      other_prev_next[1]  = grab_rel ? other_prev[1] : item.place_button;
      if (press_found) begin
        res.cmds[res.count] = '{data: 8'd0, code: {1'b0, press_idx}};
        res.count           = res.count + 2'd1;
      end else if (!any_held && any_released) begin
        res.cmds[res.count] = '{data: 8'd0, code: CMD_STOP};
        res.count           = res.count + 2'd1;
      end
      if (grab_rel) begin
        res.cmds[res.count] = '{data: 8'd0, code: CMD_GRAB};
        res.count           = res.count + 2'd1;
      end else if (place_rel) begin
        res.cmds[res.count] = '{data: 8'd0, code: CMD_PLACE};
        res.count           = res.count + 2'd1;
      end
      if (power_report) begin
        res.cmds[res.count] = '{data: power, code: CMD_SET_POWER};
        res.count           = res.count + 2'd1;
        reported_power_next = power;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_prev <= '0;
      other_prev     <= '0;
      reported_power <= POWER_CENTER;
      halted         <= 1'b0;
    end else if (fire) begin
      direction_prev <= direction_prev_next;
      other_prev     <= other_prev_next;
      reported_power <= reported_power_next;
      halted         <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> res.count == 2'd0)
    else $error("halted panel produced commands");

  a_emergency_alone: assert property (@(posedge clk) disable iff (rst)
    fire && !halted && item.emergency_button |=> halted)
    else $error("emergency did not halt the panel");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    reported_power <= POWER_MAX)
    else $error("reported power out of range");
`endif

endmodule

`default_nettype wire

FILE: src/bpce_seq.sv
// ----------------------------------------------------------------------------
// bpce_seq
// Holds the commands of one tick and hands them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bpce_seq (
  input  wire                     clk,
  input  wire                     rst,
  input  bpce_pkg::tick_result_t  res,
  input  wire                     load,
  output logic                    load_ok,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [15:0]             m_tdata,   // [3:0] command_code, [11:4] command_data
  output logic                    m_tlast
);
  import bpce_pkg::*;

  cmd_t [MAX_CMDS-1:0] queue;
  logic [1:0]          count;
  logic                pop;

  assign m_tvalid = count != 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = M_TDATA_W'({queue[0].data, queue[0].code});
  assign m_tlast  = count == 2'd1;

  // A new tick may enter as the last command of the previous one leaves.
  assign load_ok = (count == 2'd0) || (count == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      queue <= res.cmds;
    end else if (pop) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ok)
    else $error("tick loaded over pending commands");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> count == $past(res.count))
    else $error("command count not taken on load");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop && !load |=> count == $past(count) - 2'd1)
    else $error("command count did not drop on delivery");
`endif

endmodule

`default_nettype wire

FILE: src/button_panel_command_encoder_top.sv
// ----------------------------------------------------------------------------
// button_panel_command_encoder_top
// Turns polling ticks of a button panel into a stream of remote commands.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one polling tick. It is held in an
//   input register, evaluated there against the stored button samples,
//   and its zero to three commands are loaded into an output queue
//   that drives the m_ channel, one command per cycle while m_tready is
//   high, with m_tlast on the last command of the tick. The first command
//   is offered once the tick has left the input register for the queue.
//   A tick holds the output until its last command is taken; the next
//   tick may be loaded as that command leaves. Ticks with no command
//   are not loaded into the queue and need not wait for it.
//   When the receiver stalls, the queue holds its commands and the input
//   register fills, then s_tready drops.
//   The cfg channel writes the power change threshold; it is always ready.
//   Reset empties both stages, clears the samples and the halt flag, sets
//   the reported power to 100 and the threshold to 9.
// ----------------------------------------------------------------------------
`default_nettype none

module button_panel_command_encoder_top #(
  parameter int DIRECTION_COUNT = bpce_pkg::DIR_COUNT_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [3:0] direction_buttons, [4] grab_button, [5] place_button,
  // [6] emergency_button, [38:7] knob_count, [39] zero
  input  wire  [39:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [3:0] command_code, [11:4] command_data
  output logic        m_tlast,   // last_of_tick
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data
);
  import bpce_pkg::*;

  logic         in_valid;
  item_t        in_item;
  logic [7:0]   threshold;
  logic         fire;
  logic         load_ok;
  tick_result_t res;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && (res.count == 2'd0 || load_ok);
  assign s_tready  = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= item_t'(s_tdata[S_TDATA_W-2:0]);
    end
  end

  bpce_eval #(
    .DIRECTION_COUNT(DIRECTION_COUNT)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .item      (in_item),
    .fire      (fire),
    .threshold (threshold),
    .res       (res)
  );

  bpce_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .load     (fire && res.count != 2'd0),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: bench/command_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_stream_checker
// Watches the tick, command and threshold channels of the command encoder.
// It keeps its own copy of the button samples, halt flag, reported power and
// threshold, works out the commands of every accepted tick, and compares
// each accepted command with the oldest one still expected.
// ----------------------------------------------------------------------------
module command_stream_checker #(
  parameter int DIRECTION_COUNT = bpce_pkg::DIR_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          error_count,
  output int          outstanding
);
  import bpce_pkg::*;

  typedef struct {
    cmd_t cmd;
    logic last;
  } tick_command_t;

  logic [DIR_MAX-1:0] dir_samples;
  logic               grab_sample;
  logic               place_sample;
  logic [7:0]         reported_power;
  logic [7:0]         threshold;
  logic               halted;
  int                 mismatches;
  tick_command_t      expected_cmds[$];

  function automatic void encode_tick(input item_t tick);
    cmd_t   emitted[$];
    logic   now;
    logic   old;
    logic   held;
    logic   released;
    longint power;
    longint delta;
    tick_command_t rec;

    if (halted) return;

    if (tick.emergency_button) begin
      halted = 1'b1;
      rec.cmd  = cmd_t'({8'd0, CMD_EMERGENCY});
      rec.last = 1'b1;
      expected_cmds.push_back(rec);
      return;
    end

    // The scan stops at the first new press; later buttons keep old samples.
    held     = 1'b0;
    released = 1'b0;
    for (int i = 0; i < DIRECTION_COUNT; i++) begin
      now = (i < DIR_FIELD_W) ? tick.direction_buttons[i] : 1'b0;
      old = dir_samples[i];
      dir_samples[i] = now;
      held     = held | now;
      released = released | (old & ~now);
      if (now && !old) begin
        emitted.push_back(cmd_t'({8'd0, 4'(i)}));
        break;
      end
    end
    if (!held && released) emitted.push_back(cmd_t'({8'd0, CMD_STOP}));

    // A grab release ends the scan, so place is not sampled in that tick.
    if (grab_sample && !tick.grab_button) begin
      grab_sample = 1'b0;
      emitted.push_back(cmd_t'({8'd0, CMD_GRAB}));
    end else begin
      grab_sample = tick.grab_button;
      if (place_sample && !tick.place_button)
        emitted.push_back(cmd_t'({8'd0, CMD_PLACE}));
      place_sample = tick.place_button;
    end

    power = longint'(tick.knob_count) / 2 + longint'(POWER_CENTER);
    if (power < longint'(POWER_MIN)) power = longint'(POWER_MIN);
    if (power > longint'(POWER_MAX)) power = longint'(POWER_MAX);
    delta = power - longint'(reported_power);
    if (delta < 0) delta = -delta;
    if (delta > longint'(threshold)) begin
      reported_power = power[7:0];
      emitted.push_back(cmd_t'({power[7:0], CMD_SET_POWER}));
    end

    foreach (emitted[k]) begin
      rec.cmd  = emitted[k];
      rec.last = (k == emitted.size() - 1);
      expected_cmds.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    tick_command_t want;
    cmd_t          got;

    if (rst) begin
      dir_samples    = '0;
      grab_sample    = 1'b0;
      place_sample   = 1'b0;
      reported_power = POWER_CENTER;
      threshold      = THRESHOLD_RESET;
      halted         = 1'b0;
      mismatches     = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;

      // Results are retired before new ticks are predicted: a command never
      // belongs to a tick accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got = m_tdata[11:0];
        if (expected_cmds.size() == 0) begin
          $error("unexpected command: code %0d, data %0d, last %0d",
                 got.code, got.data, m_tlast);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.code !== want.cmd.code) begin
            $error("command_code mismatch: expected %0d, actual %0d",
                   want.cmd.code, got.code);
            mismatches++;
          end
          if (got.data !== want.cmd.data) begin
            $error("command_data mismatch: expected %0d, actual %0d",
                   want.cmd.data, got.data);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_tick mismatch: expected %0d, actual %0d",
                   want.last, m_tlast);
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) encode_tick(item_t'(s_tdata[38:0]));
    end
    error_count <= mismatches;
    outstanding <= expected_cmds.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives polling ticks and threshold writes into the button panel command
// encoder with random gaps and receiver stalls, and reports the outcome of
// the command stream checker that runs beside it.
// ----------------------------------------------------------------------------
module testbench;
  import bpce_pkg::*;

  localparam int DIR_COUNT     = DIR_COUNT_DEFAULT;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        steady = 1'b0;
  int          error_count;
  int          outstanding;
  int          cycle_count = 0;

  button_panel_command_encoder_top #(.DIRECTION_COUNT(DIR_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  command_stream_checker #(.DIRECTION_COUNT(DIR_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .error_count(error_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic item_t make_tick(logic [3:0] dirs, int grab, int place,
                                      int stop_all, int knob);
    item_t tick;
    tick.direction_buttons = dirs;
    tick.grab_button       = grab[0];
    tick.place_button      = place[0];
    tick.emergency_button  = stop_all[0];
    tick.knob_count        = knob;
    return tick;
  endfunction

  function automatic item_t random_tick();
    int knob;
    case ($urandom_range(9))
      0:       knob = $urandom();
      1:       knob = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: knob = int'($urandom_range(600)) - 300;
    endcase
    return make_tick(4'($urandom_range(15)), $urandom_range(1), $urandom_range(1),
                     0, knob);
  endfunction

  // Holds the request until it is taken, then sometimes leaves a gap.
  task automatic send_tick(input item_t tick);
    s_tdata  <= {1'b0, tick};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!steady && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Waits for every expected command, then for ticks that produce none.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    settle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_tick(random_tick());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset threshold and the power reported at 100.
    send_tick(make_tick(4'b0000, 0, 0, 0, 0));
    send_tick(make_tick(4'b0001, 0, 0, 0, 0));
    send_tick(make_tick(4'b0011, 1, 1, 0, 0));
    send_tick(make_tick(4'b1111, 1, 1, 0, 0));
    send_tick(make_tick(4'b1111, 1, 1, 0, 0));
    // Stop, grab release and a power change in one tick; place waits.
    send_tick(make_tick(4'b0000, 0, 0, 0, 20));
    send_tick(make_tick(4'b0000, 0, 0, 0, 20));
    send_tick(make_tick(4'b1000, 1, 0, 0, 32'sh80000000));
    send_tick(make_tick(4'b0000, 0, 0, 0, 32'sh7fffffff));
    send_tick(make_tick(4'b0100, 0, 1, 0, 32'sh7fffffff));
    send_tick(make_tick(4'b0100, 0, 0, 0, 0));
    // A change equal to the threshold is not reported, one above it is.
    send_tick(make_tick(4'b0000, 0, 0, 0, 18));
    send_tick(make_tick(4'b0000, 0, 0, 0, -1));
    send_tick(make_tick(4'b0000, 0, 0, 0, -20));
    send_tick(make_tick(4'b0110, 0, 0, 0, -21));
    send_tick(make_tick(4'b0100, 0, 0, 0, 200));
    send_tick(make_tick(4'b0000, 1, 1, 0, -200));
    send_tick(make_tick(4'b0000, 1, 1, 0, 1));

    write_threshold(8'd0);
    run_random(80);
    write_threshold(POWER_MAX);
    run_random(50);
    write_threshold(8'($urandom_range(1, 199)));
    steady <= 1'b1;
    run_random(100);
    steady <= 1'b0;
    write_threshold(THRESHOLD_RESET);
    run_random(100);

    // Emergency stop halts the block; later ticks must produce nothing.
    send_tick(make_tick(4'b1111, 1, 1, 1, 32'sh7fffffff));
    send_tick(make_tick(4'b0000, 0, 0, 1, 32'sh80000000));
    send_tick(make_tick(4'b0101, 0, 0, 0, 1000));
    send_tick(make_tick(4'b0000, 0, 0, 0, 0));
    settle();

    if (error_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
